// File: hw/rtl/sorted_record_table_unit_macros.svh
// Assertion macros shared by the sorted record table RTL.
`ifndef SORTED_RECORD_TABLE_UNIT_MACROS_SVH
`define SORTED_RECORD_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sorted_record_table_unit: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorted_record_table_unit: assertion failed");
`else
`define SRT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/srt_pkg.sv
// Shared types and codes of the sorted record table.
package srt_pkg;

  typedef struct packed {
    logic        [63:0] name;
    logic signed [31:0] id;
    logic signed [31:0] salary;
  } rec_t;

  typedef struct packed {
    logic name_eq;
    logic name_gt;
    logic sal_eq;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_INSERT    = 3'd0,
    K_DELETE    = 3'd1,
    K_FIND_NAME = 3'd2,
    K_FIND_SAL  = 3'd3,
    K_SET_ID    = 3'd4,
    K_SET_SAL   = 3'd5,
    K_LIST      = 3'd6
  } kind_e;

endpackage

// File: hw/rtl/srt_ram.sv
// Record memory: one write port, one read port with registered read data.
module srt_ram import srt_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  rec_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output rec_t          rdata_o
);

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/srt_cmp.sv
// Shared compare unit: key order and equality, salary equality.
module srt_cmp import srt_pkg::*; (
  input  rec_t               rec_i,
  input  logic        [63:0] key_i,
  input  logic signed [31:0] sal_i,
  output cmp_res_t           res_o
);

  assign res_o.name_eq = (rec_i.name == key_i);
  assign res_o.name_gt = (rec_i.name > key_i);
  assign res_o.sal_eq  = (rec_i.salary == sal_i);

endmodule

// File: hw/rtl/sorted_record_table_unit.sv
// Sorted record table: sequencer walking a record memory through one compare unit.
// Insert, find and set walk down; list and salary search walk up; a delete scans down, then
// shifts up. One item at a time, the next one accepted in the cycle busy drops; the single read
// port paces the walk at one entry per cycle. Results are registered and strobe in the cycle
// after they are decided.
// Reset (rst_ni low, asynchronous) empties the table; stored records need no clearing.
module sorted_record_table_unit import srt_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int NAME_CHARS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic        [2:0]  kind_i,
  input  logic        [63:0] key_name_i,
  input  logic signed [31:0] id_value_i,
  input  logic signed [31:0] salary_value_i,
  output logic               result_valid_o,
  output logic        [1:0]  status_o,
  output logic        [5:0]  position_o,
  output logic        [6:0]  match_number_o,
  output logic        [63:0] rec_name_o,
  output logic signed [31:0] rec_id_o,
  output logic signed [31:0] rec_salary_o,
  output logic               last_o
);

`include "sorted_record_table_unit_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states:
  //   S_INS   walk down from the top, moving larger keys up by one slot
  //   S_PUT0  drop the new record into slot zero after the walk ran out
  //   S_FIND  walk down, stop at the first key hit (the last match in order)
  //   S_SHIFT close the gap left by a delete, walking up
  //   S_SCAN  walk up for list or salary search
  //   S_FLUSH send the held salary match, or a miss if none, as the final transaction
  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_PUT0, S_FIND, S_SHIFT, S_SCAN, S_FLUSH
  } state_e;

  typedef struct packed {
    status_e    status;
    logic [5:0] pos;
    logic [6:0] num;
    rec_t       rec;
    logic       last;
  } res_t;

  // Cut the key to NAME_CHARS bytes and clear everything after the first zero byte.
  function automatic logic [63:0] norm_key(logic [63:0] k);
    logic [63:0] o;
    logic        alive;
    o     = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (alive && (b < NAME_CHARS) && (k[63-8*b -: 8] != 8'd0)) begin
        o[63-8*b -: 8] = k[63-8*b -: 8];
      end else begin
        alive = 1'b0;
      end
    end
    return o;
  endfunction

  // Failed transactions carry zero payload and always close the item.
  function automatic res_t mk_res(status_e st, logic [AW-1:0] pos, logic [6:0] num,
                                  rec_t r, logic lst);
    res_t o;
    o        = '0;
    o.status = st;
    o.last   = lst;
    if (st == ST_OK) begin
      o.pos = 6'(pos);
      o.num = num;
      o.rec = r;
    end
    return o;
  endfunction

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  kind_e              kind_q, kind_d;
  logic [63:0]        key_q, key_d;
  logic signed [31:0] idv_q, idv_d;
  logic signed [31:0] sal_q, sal_d;
  logic [AW-1:0]      idx_q, idx_d;     // next address to read
  logic               iss_q, iss_d;     // reads still to issue
  logic               dv_q, dv_d;       // read data is valid this cycle
  logic [AW-1:0]      daddr_q, daddr_d; // address of the read data
  logic [6:0]         num_q, num_d;     // salary matches found so far
  logic               pend_q, pend_d;   // a salary match is held back
  rec_t               prec_q, prec_d;
  logic [AW-1:0]      ppos_q, ppos_d;
  logic               out_vld_q, out_vld_d;
  res_t               out_q, out_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rec_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  rec_t          rdata;
  cmp_res_t      cmp;
  rec_t          new_rec;
  rec_t          upd_rec;
  logic [AW-1:0] last_idx;
  logic          walk_dn;
  logic          walk_up;

  srt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  srt_cmp u_cmp (
    .rec_i (rdata),
    .key_i (key_q),
    .sal_i (sal_q),
    .res_o (cmp)
  );

  assign new_rec  = '{name: key_q, id: idv_q, salary: sal_q};
  assign last_idx = AW'(cnt_q - 1'b1);
  assign walk_dn  = (state_q == S_INS) || (state_q == S_FIND);
  assign walk_up  = (state_q == S_SHIFT) || (state_q == S_SCAN);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    kind_d    = kind_q;
    key_d     = key_q;
    idv_d     = idv_q;
    sal_d     = sal_q;
    idx_d     = idx_q;
    iss_d     = iss_q;
    dv_d      = 1'b0;
    daddr_d   = daddr_q;
    num_d     = num_q;
    pend_d    = pend_q;
    prec_d    = prec_q;
    ppos_d    = ppos_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_rec;
    upd_rec   = rdata;

    // Read issue: one address a cycle, downward or upward.
    if (iss_q && (walk_dn || walk_up)) begin
      dv_d    = 1'b1;
      daddr_d = idx_q;
      if (walk_dn) begin
        if (idx_q == '0) begin
          iss_d = 1'b0;
        end else begin
          idx_d = idx_q - AW'(1);
        end
      end else begin
        if (idx_q == last_idx) begin
          iss_d = 1'b0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_e'(kind_i);
          key_d  = norm_key(key_name_i);
          idv_d  = id_value_i;
          sal_d  = salary_value_i;
          num_d  = '0;
          pend_d = 1'b0;
          iss_d  = (cnt_q != '0);
          idx_d  = last_idx;
          case (kind_e'(kind_i))
            K_INSERT: state_d = S_INS;
            K_DELETE, K_FIND_NAME, K_SET_ID, K_SET_SAL: state_d = S_FIND;
            K_FIND_SAL, K_LIST: begin
              state_d = S_SCAN;
              idx_d   = '0;
            end
            default: begin
              state_d = S_IDLE;
              iss_d   = 1'b0;
            end
          endcase
        end
      end

      S_INS: begin
        if (cnt_q == CW'(DEPTH)) begin
          out_vld_d = 1'b1;
          out_d     = mk_res(ST_FULL, '0, '0, new_rec, 1'b1);
          iss_d     = 1'b0;
          state_d   = S_IDLE;
        end else if (cnt_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          out_vld_d = 1'b1;
          out_d     = mk_res(ST_OK, '0, '0, new_rec, 1'b1);
          cnt_d     = cnt_q + 1'b1;
          state_d   = S_IDLE;
        end else if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = daddr_q + AW'(1);
          if (cmp.name_gt) begin
            // Move the larger key up; keep walking, or fall to slot zero.
            mem_wdata = rdata;
            if (daddr_q == '0) begin
              state_d = S_PUT0;
            end
          end else begin
            out_vld_d = 1'b1;
            out_d     = mk_res(ST_OK, daddr_q + AW'(1), '0, new_rec, 1'b1);
            cnt_d     = cnt_q + 1'b1;
            iss_d     = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end

      S_PUT0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        out_vld_d = 1'b1;
        out_d     = mk_res(ST_OK, '0, '0, new_rec, 1'b1);
        cnt_d     = cnt_q + 1'b1;
        iss_d     = 1'b0;
        state_d   = S_IDLE;
      end

      S_FIND: begin
        if (cnt_q == '0) begin
          out_vld_d = 1'b1;
          out_d     = mk_res(ST_MISS, '0, '0, new_rec, 1'b1);
          state_d   = S_IDLE;
        end else if (dv_q) begin
          if (cmp.name_eq) begin
            iss_d   = 1'b0;
            state_d = S_IDLE;
            if (kind_q == K_SET_ID) begin
              upd_rec.id = idv_q;
              mem_we     = 1'b1;
            end else if (kind_q == K_SET_SAL) begin
              upd_rec.salary = sal_q;
              mem_we         = 1'b1;
            end
            mem_waddr = daddr_q;
            mem_wdata = upd_rec;
            out_vld_d = 1'b1;
            out_d     = mk_res(ST_OK, daddr_q, '0, upd_rec, 1'b1);
            if (kind_q == K_DELETE) begin
              if (daddr_q == last_idx) begin
                cnt_d = cnt_q - 1'b1;
              end else begin
                // Close the gap: restart reads just above the removed slot.
                state_d = S_SHIFT;
                idx_d   = daddr_q + AW'(1);
                iss_d   = 1'b1;
                dv_d    = 1'b0;
              end
            end
          end else if (daddr_q == '0) begin
            out_vld_d = 1'b1;
            out_d     = mk_res(ST_MISS, '0, '0, new_rec, 1'b1);
            iss_d     = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = daddr_q - AW'(1);
          mem_wdata = rdata;
          if (daddr_q == last_idx) begin
            cnt_d   = cnt_q - 1'b1;
            iss_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        if (cnt_q == '0) begin
          out_vld_d = 1'b1;
          out_d     = mk_res(ST_MISS, '0, '0, new_rec, 1'b1);
          state_d   = S_IDLE;
        end else if (dv_q) begin
          if (kind_q == K_LIST) begin
            out_vld_d = 1'b1;
            out_d     = mk_res(ST_OK, daddr_q, 7'(daddr_q) + 7'd1, rdata,
                               daddr_q == last_idx);
            if (daddr_q == last_idx) begin
              state_d = S_IDLE;
            end
          end else begin
            // Hold each match back one step so the final one can be flagged.
            if (cmp.sal_eq) begin
              if (pend_q) begin
                out_vld_d = 1'b1;
                out_d     = mk_res(ST_OK, ppos_q, num_q, prec_q, 1'b0);
              end
              pend_d = 1'b1;
              prec_d = rdata;
              ppos_d = daddr_q;
              num_d  = num_q + 7'd1;
            end
            if (daddr_q == last_idx) begin
              state_d = S_FLUSH;
            end
          end
        end
      end

      S_FLUSH: begin
        out_vld_d = 1'b1;
        if (pend_q) begin
          out_d = mk_res(ST_OK, ppos_q, num_q, prec_q, 1'b1);
        end else begin
          out_d = mk_res(ST_MISS, '0, '0, prec_q, 1'b1);
        end
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
        iss_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      kind_q    <= K_INSERT;
      key_q     <= '0;
      idv_q     <= '0;
      sal_q     <= '0;
      idx_q     <= '0;
      iss_q     <= 1'b0;
      dv_q      <= 1'b0;
      daddr_q   <= '0;
      num_q     <= '0;
      pend_q    <= 1'b0;
      prec_q    <= '0;
      ppos_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      kind_q    <= kind_d;
      key_q     <= key_d;
      idv_q     <= idv_d;
      sal_q     <= sal_d;
      idx_q     <= idx_d;
      iss_q     <= iss_d;
      dv_q      <= dv_d;
      daddr_q   <= daddr_d;
      num_q     <= num_d;
      pend_q    <= pend_d;
      prec_q    <= prec_d;
      ppos_q    <= ppos_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  assign mem_raddr      = idx_q;
  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = out_vld_q;
  assign status_o       = out_q.status;
  assign position_o     = out_q.pos;
  assign match_number_o = out_q.num;
  assign rec_name_o     = out_q.rec.name;
  assign rec_id_o       = out_q.rec.id;
  assign rec_salary_o   = out_q.rec.salary;
  assign last_o         = out_q.last;

  // An idle cycle decides nothing, so no transaction follows it.
  `SRT_ASSERT_NEXT(a_idle_quiet, clk_i, rst_ni, !busy_o, !result_valid_o)
  `SRT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH))
  `SRT_ASSERT_IMP(a_full_no_write, clk_i, rst_ni, state_q == S_INS && cnt_q == CW'(DEPTH), !mem_we)
  `SRT_ASSERT_IMP(a_fail_closes, clk_i, rst_ni, result_valid_o && status_o != ST_OK, last_o && position_o == 6'd0)

endmodule
